>>> rtl/core/qdpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdpr_pkg
// shared types and constants of the quantized dot-product requantizer
// ----------------------------------------------------------------------------
package qdpr_pkg;

    localparam int ACC_W   = 40;
    localparam int PROD_W  = 18;
    localparam int MAG_W   = 40;
    localparam int HALF_W  = 20;
    localparam int MULT_W  = 31;
    localparam int PP_W    = HALF_W + MULT_W;
    localparam int FULL_W  = 72;
    localparam int Q_W     = 11;
    localparam int ADDR_W  = 5;

    localparam logic [Q_W-1:0] Q_CLAMP     = 11'd1024;
    localparam logic [7:0]     RESULT_MAX  = 8'd255;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // register indexes
    localparam logic [2:0] REG_ACT_ZP  = 3'd0;
    localparam logic [2:0] REG_WGT_ZP  = 3'd1;
    localparam logic [2:0] REG_OUT_ZP  = 3'd2;
    localparam logic [2:0] REG_MULT    = 3'd3;
    localparam logic [2:0] REG_SHIFT   = 3'd4;
    localparam logic [2:0] REG_BIAS_EN = 3'd5;

    typedef struct packed {
        logic [7:0]        act_zero_point;
        logic signed [7:0] weight_zero_point;
        logic [7:0]        result_zp;
        logic [MULT_W-1:0] scale_multiplier;
        logic [5:0]        scale_shift;
        logic              bias_enable;
    } cfg_t;

    typedef struct packed {
        logic acc_en;
        logic capture;
        logic bias_step;
        logic abs_step;
        logic mul_lo;
        logic mul_hi;
        logic sum_step;
        logic shift_step;
        logic load_out;
    } cmd_t;

endpackage

>>> rtl/core/quantized_dot_product_requantizer.sv
`timescale 1ns / 1ps
// steps: an item without last is absorbed into the accumulator; after a run's last item is
//   accepted, its result passes bias, abs, two multiply halves (the 20x31 multiplier used
//   twice for the 40x31 product), sum, shift and saturate, which waits for a free output register
// throughput: one item per cycle within a run; no item is taken until a run's result is loaded
// reset: rst_n asynchronous, active low; clears the accumulator, the sequencer,
//   the output valid flag and loads the register reset values
// ----------------------------------------------------------------------------
// quantized_dot_product_requantizer
// uint8 x int8 dot product with fixed-point requantization to a uint8 byte
// ----------------------------------------------------------------------------
module quantized_dot_product_requantizer
(
    input  logic                         clk,
    input  logic                         rst_n,

    // input items
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [47:0]                  s_axis_tdata,   // activation[7:0], weight[15:8], bias[47:16]
    input  logic                         s_axis_tlast,   // last element of the dot product

    // result items
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // result_byte[7:0]

    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qdpr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    qdpr_pkg::cfg_t cfg;
    qdpr_pkg::cmd_t cmd;

    // zero points, scale and bias enable; it is up to the user to write them only while no run is open
    qdpr_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accepts items only in the accumulate state, the output
    // register keeps a finished item while the next run streams in
    qdpr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // saturating 40-bit accumulate, bias, rounding scale and output clamp
    qdpr_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .activation  (s_axis_tdata[7:0]),
        .weight      (s_axis_tdata[15:8]),
        .bias        (s_axis_tdata[47:16]),
        .result_byte (m_axis_tdata)
    );

endmodule

>>> rtl/core/qdpr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdpr_cfg_regs
// apb register file holding zero points, scale and bias enable
// ----------------------------------------------------------------------------
module qdpr_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qdpr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output qdpr_pkg::cfg_t               cfg
);

    qdpr_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.act_zero_point    <= 8'd0;
            cfg_reg.weight_zero_point <= 8'sd0;
            cfg_reg.result_zp         <= 8'd0;
            cfg_reg.scale_multiplier  <= 31'd1073741824;
            cfg_reg.scale_shift       <= 6'd30;
            cfg_reg.bias_enable       <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                qdpr_pkg::REG_ACT_ZP:  cfg_reg.act_zero_point    <= pwdata[7:0];
                qdpr_pkg::REG_WGT_ZP:  cfg_reg.weight_zero_point <= pwdata[7:0];
                qdpr_pkg::REG_OUT_ZP:  cfg_reg.result_zp         <= pwdata[7:0];
                qdpr_pkg::REG_MULT:    cfg_reg.scale_multiplier  <= pwdata[30:0];
                qdpr_pkg::REG_SHIFT:   cfg_reg.scale_shift       <= pwdata[5:0];
                qdpr_pkg::REG_BIAS_EN: cfg_reg.bias_enable       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            qdpr_pkg::REG_ACT_ZP:  prdata = {24'd0, cfg_reg.act_zero_point};
            qdpr_pkg::REG_WGT_ZP:  prdata = {{24{cfg_reg.weight_zero_point[7]}},
                                             cfg_reg.weight_zero_point};
            qdpr_pkg::REG_OUT_ZP:  prdata = {24'd0, cfg_reg.result_zp};
            qdpr_pkg::REG_MULT:    prdata = {1'b0, cfg_reg.scale_multiplier};
            qdpr_pkg::REG_SHIFT:   prdata = {26'd0, cfg_reg.scale_shift};
            qdpr_pkg::REG_BIAS_EN: prdata = {31'd0, cfg_reg.bias_enable};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/core/qdpr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdpr_datapath
// multiply-accumulate, bias, split scale multiply, rounding shift, saturation
// ----------------------------------------------------------------------------
module qdpr_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  qdpr_pkg::cfg_t      cfg,
    input  qdpr_pkg::cmd_t      cmd,
    input  logic [7:0]          activation,
    input  logic signed [7:0]   weight,
    input  logic signed [31:0]  bias,
    output logic [7:0]          result_byte
);

    logic signed [qdpr_pkg::ACC_W-1:0]  acc_reg,  acc_next;
    logic signed [31:0]                 bias_reg;
    logic signed [qdpr_pkg::ACC_W-1:0]  sum_reg,  sum_next;
    logic [qdpr_pkg::MAG_W-1:0]         mag_reg,  mag_next;
    logic                               neg_reg;
    logic [qdpr_pkg::PP_W-1:0]          pp_lo_reg, pp_hi_reg, pp_next;
    logic [qdpr_pkg::FULL_W-1:0]        full_reg, full_next, half, shifted;
    logic [qdpr_pkg::Q_W-1:0]           q_reg,    q_next;
    logic [7:0]                         out_reg,  out_next;

    logic signed [8:0]                  a_diff, w_diff;
    logic signed [qdpr_pkg::PROD_W-1:0] prod;
    logic signed [qdpr_pkg::ACC_W:0]    mac_sum, bias_sum;
    logic signed [11:0]                 r;

    function automatic logic signed [qdpr_pkg::ACC_W-1:0] sat40
        (input logic signed [qdpr_pkg::ACC_W:0] v);
        logic signed [qdpr_pkg::ACC_W-1:0] res;
        begin
            if (v[qdpr_pkg::ACC_W] != v[qdpr_pkg::ACC_W-1])
                res = v[qdpr_pkg::ACC_W] ? qdpr_pkg::ACC_MIN : qdpr_pkg::ACC_MAX;
            else
                res = v[qdpr_pkg::ACC_W-1:0];
            return res;
        end
    endfunction

    // mac
    assign a_diff  = $signed({1'b0, activation}) - $signed({1'b0, cfg.act_zero_point});
    assign w_diff  = $signed({weight[7], weight})
                   - $signed({cfg.weight_zero_point[7], cfg.weight_zero_point});
    assign prod    = a_diff * w_diff;
    assign mac_sum = $signed({acc_reg[qdpr_pkg::ACC_W-1], acc_reg})
                   + $signed({{(qdpr_pkg::ACC_W+1-qdpr_pkg::PROD_W){prod[qdpr_pkg::PROD_W-1]}},
                              prod});

    // bias
    assign bias_sum = $signed({acc_reg[qdpr_pkg::ACC_W-1], acc_reg})
                    + (cfg.bias_enable ? $signed({{9{bias_reg[31]}}, bias_reg})
                                       : $signed(41'd0));
    assign sum_next = sat40(bias_sum);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_en)
            acc_next = sat40(mac_sum);
        else if (cmd.bias_step)
            acc_next = '0;
    end

    assign mag_next = sum_reg[qdpr_pkg::ACC_W-1] ? qdpr_pkg::MAG_W'(-sum_reg)
                                                 : qdpr_pkg::MAG_W'(sum_reg);

    // one 20x31 partial product per cycle
    assign pp_next = cmd.mul_lo
                   ? qdpr_pkg::PP_W'(mag_reg[qdpr_pkg::HALF_W-1:0]) *
                     qdpr_pkg::PP_W'(cfg.scale_multiplier)
                   : qdpr_pkg::PP_W'(mag_reg[qdpr_pkg::MAG_W-1:qdpr_pkg::HALF_W]) *
                     qdpr_pkg::PP_W'(cfg.scale_multiplier);

    // rounding constant, none for shift zero
    assign half = (cfg.scale_shift == 6'd0) ? '0
                : (qdpr_pkg::FULL_W'(1) << (cfg.scale_shift - 6'd1));

    assign full_next = qdpr_pkg::FULL_W'(pp_lo_reg)
                     + {1'b0, pp_hi_reg, {qdpr_pkg::HALF_W{1'b0}}}
                     + half;

    assign shifted = full_reg >> cfg.scale_shift;
    assign q_next  = ((|shifted[qdpr_pkg::FULL_W-1:qdpr_pkg::Q_W]) ||
                      (shifted[qdpr_pkg::Q_W-1:0] > qdpr_pkg::Q_CLAMP))
                   ? qdpr_pkg::Q_CLAMP : shifted[qdpr_pkg::Q_W-1:0];

    assign r = neg_reg ? ($signed({4'd0, cfg.result_zp}) - $signed({1'b0, q_reg}))
                       : ($signed({4'd0, cfg.result_zp}) + $signed({1'b0, q_reg}));

    always_comb
    begin
        if (r[11])
            out_next = 8'd0;
        else if (r > $signed({4'd0, qdpr_pkg::RESULT_MAX}))
            out_next = qdpr_pkg::RESULT_MAX;
        else
            out_next = r[7:0];
    end

    // accumulator is control state, the rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            bias_reg <= bias;
        if (cmd.bias_step)
            sum_reg <= sum_next;
        if (cmd.abs_step)
        begin
            mag_reg <= mag_next;
            neg_reg <= sum_reg[qdpr_pkg::ACC_W-1];
        end
        if (cmd.mul_lo)
            pp_lo_reg <= pp_next;
        if (cmd.mul_hi)
            pp_hi_reg <= pp_next;
        if (cmd.sum_step)
            full_reg <= full_next;
        if (cmd.shift_step)
            q_reg <= q_next;
        if (cmd.load_out)
            out_reg <= out_next;
    end

    assign result_byte = out_reg;

    // accumulator starts the next run from zero
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bias_step |=> (acc_reg == '0))
        else $error("accumulator not cleared after run end");

endmodule

>>> rtl/core/qdpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdpr_ctrl
// sequencer for accumulate, requantize steps and the output register
// ----------------------------------------------------------------------------
module qdpr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output qdpr_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIAS,
        S_ABS,
        S_MLO,
        S_MHI,
        S_SUM,
        S_SHIFT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                cmd.acc_en  = accept;
                cmd.capture = accept && in_last;
                if (accept && in_last)
                    state_next = S_BIAS;
            end
            S_BIAS:
            begin
                cmd.bias_step = 1'b1;
                state_next    = S_ABS;
            end
            S_ABS:
            begin
                cmd.abs_step = 1'b1;
                state_next   = S_MLO;
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                state_next   = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_last_starts_requant: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (state_reg == S_BIAS))
        else $error("run end did not start requantization");

    a_mid_run_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_last) |=> (state_reg == S_IDLE))
        else $error("mid-run item left the accumulate state");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_valid_reg) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not loaded into free output register");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the quantized dot-product requantizer: items are
// streamed in with random gaps and results drained with random stalls, every
// result byte is checked in order against a behavioural dot-product and
// requantisation predictor, and the registers are checked by read-back
// ----------------------------------------------------------------------------
module tb_top;
    import qdpr_pkg::*;

    localparam int GAP_MAX       = 12;    // longest gap or stall per item
    localparam int SETTLE_CYCLES = 16;    // result latency with some margin
    localparam int DRAIN_LIMIT   = 5000;  // cycles allowed for results to drain
    localparam int RANDOM_ITEMS  = 1950;
    localparam int LONG_RUN      = 512;
    localparam int NUM_REGS      = 6;

    // register indexes with no register behind them
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata;   // activation[7:0], weight[15:8], bias[47:16]
    logic              s_axis_tlast;   // last element of the dot product
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // result_byte[7:0]
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor copy of the register file and the running dot product
    logic [7:0]         cfg_act_zp;
    logic signed [7:0]  cfg_wgt_zp;
    logic [7:0]         cfg_out_zp;
    logic [30:0]        cfg_mult;
    logic [5:0]         cfg_shift;
    logic               cfg_bias_en;
    logic signed [39:0] dot_acc;

    logic [7:0] expected_bytes[$];   // result bytes still owed by the block
    int         errors;
    int         items_sent;
    bit         tx_gaps;             // sender idles between items
    bit         rx_stalls;           // receiver stalls between items

    quantized_dot_product_requantizer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // accumulator additions clip to the 40-bit signed range
    function automatic logic signed [39:0] sat_acc(longint v);
        if (v > ACC_HI)
            return ACC_MAX;
        if (v < ACC_LO)
            return ACC_MIN;
        return v[39:0];
    endfunction

    // scale the magnitude, round half away from zero, clamp, add zero point, clip
    function automatic logic [7:0] requantise(logic signed [39:0] total);
        logic [39:0]  mag;
        logic [127:0] scaled;
        int           q;
        int           r;
        mag    = (total < 0) ? 40'(-total) : 40'(total);
        scaled = 128'(mag) * 128'(cfg_mult);
        if (cfg_shift != 0)
            scaled = scaled + (128'd1 << (cfg_shift - 1));
        scaled = scaled >> cfg_shift;
        q = (scaled > 128'(Q_CLAMP)) ? int'(Q_CLAMP) : int'(scaled[10:0]);
        r = (total < 0) ? int'(cfg_out_zp) - q : int'(cfg_out_zp) + q;
        if (r > int'(RESULT_MAX))
            r = int'(RESULT_MAX);
        if (r < 0)
            r = 0;
        return r[7:0];
    endfunction

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------

    // setup, access, then a return to idle on the bus
    task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(logic [2:0] idx);
        logic [31:0] got;
        logic [31:0] want;
        logic [31:0] mask;
        mask = 32'd0;
        want = 32'd0;
        case (idx)
            REG_ACT_ZP:  begin want = {24'd0, cfg_act_zp};  mask = 32'h0000_00FF; end
            REG_WGT_ZP:  begin want = {24'd0, cfg_wgt_zp};  mask = 32'h0000_00FF; end
            REG_OUT_ZP:  begin want = {24'd0, cfg_out_zp};  mask = 32'h0000_00FF; end
            REG_MULT:    begin want = {1'b0, cfg_mult};     mask = 32'h7FFF_FFFF; end
            REG_SHIFT:   begin want = {26'd0, cfg_shift};   mask = 32'h0000_003F; end
            REG_BIAS_EN: begin want = {31'd0, cfg_bias_en}; mask = 32'h0000_0001; end
            default: ;
        endcase
        if (mask != 32'd0)
        begin
            apb_access(1'b0, idx, 32'd0, got);
            if ((got & mask) != want)
                report($sformatf("register %0d reads %h, expected %h", idx, got & mask, want));
        end
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_ACT_ZP:  cfg_act_zp  = value[7:0];
            REG_WGT_ZP:  cfg_wgt_zp  = value[7:0];
            REG_OUT_ZP:  cfg_out_zp  = value[7:0];
            REG_MULT:    cfg_mult    = value[30:0];
            REG_SHIFT:   cfg_shift   = value[5:0];
            REG_BIAS_EN: cfg_bias_en = value[0];
            default: ;   // writes to spare indexes are dropped
        endcase
        check_reg(idx);
    endtask

    task automatic apply_config(logic [31:0] act_zp, logic [31:0] wgt_zp, logic [31:0] out_zp,
                                logic [31:0] mult, logic [31:0] shift, logic [31:0] bias_en);
        set_reg(REG_ACT_ZP, act_zp);
        set_reg(REG_WGT_ZP, wgt_zp);
        set_reg(REG_OUT_ZP, out_zp);
        set_reg(REG_MULT, mult);
        set_reg(REG_SHIFT, shift);
        set_reg(REG_BIAS_EN, bias_en);
    endtask

    // ------------------------------------------------------------------------
    // item sender, also feeds the predictor on every accepted item
    // ------------------------------------------------------------------------
    task automatic send_elem(logic [7:0] act, logic signed [7:0] wgt,
                             logic signed [31:0] bias, logic last);
        int                 gap;
        int                 a;
        int                 w;
        logic signed [39:0] total;
        gap = tx_gaps ? $urandom_range(0, GAP_MAX) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bias, wgt, act};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);

        a = int'(act) - int'(cfg_act_zp);
        w = int'(wgt) - int'(cfg_wgt_zp);
        dot_acc = sat_acc(longint'(dot_acc) + longint'(a) * longint'(w));
        if (last)
        begin
            total = dot_acc;
            if (cfg_bias_en)
                total = sat_acc(longint'(total) + longint'(bias));
            dot_acc = '0;
            expected_bytes.push_back(requantise(total));
        end
        items_sent++;
    endtask

    // stop sending, let every owed result drain, then cover the pipeline latency
    task automatic settle();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_run(int len);
        logic [7:0]         act;
        logic signed [7:0]  wgt;
        logic signed [31:0] bias;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0: act = cfg_act_zp;
                1: act = 8'(pick(0, 255));
                default: act = 8'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: wgt = cfg_wgt_zp;
                1: wgt = 8'(pick(32'h80, 32'h7F));
                default: wgt = 8'($urandom);
            endcase
            // mostly small biases so that scaled results stay in range
            if ($urandom_range(0, 3) == 0)
                bias = $urandom;
            else
                bias = $urandom_range(0, 20'hFFFFF) - 20'h80000;
            send_elem(act, wgt, bias, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // result checker, with its own random stalls on tready
    // ------------------------------------------------------------------------
    initial
    begin
        int         stall;
        logic [7:0] want;
        stall = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                    report($sformatf("result %0d arrived with none owed", m_axis_tdata));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want)
                        report($sformatf("result_byte %0d, expected %0d", m_axis_tdata, want));
                end
                stall = rx_stalls ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values read back, then unity scale: result is the clipped sum
    task automatic test_reset_defaults();
        for (int i = 0; i < NUM_REGS; i++)
            check_reg(3'(i));
        send_elem(8'd3, 8'sd5, $urandom, 1'b1);
        send_elem(8'd255, 8'sd127, $urandom, 1'b0);
        send_elem(8'd255, 8'sd127, 32'h7FFF_FFFF, 1'b1);   // bias ignored, disabled
    endtask

    // spare indexes leave the file alone, every bit of every register toggles
    task automatic test_register_file();
        settle();
        set_reg(REG_SPARE_A, $urandom);
        set_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        for (int i = 0; i < NUM_REGS; i++)
            check_reg(3'(i));
        for (int i = 0; i < NUM_REGS; i++)
            set_reg(3'(i), 32'hFFFF_FFFF);
        for (int i = 0; i < NUM_REGS; i++)
            set_reg(3'(i), 32'h0000_0000);
    endtask

    // activation and weight extremes, against both zero-point extremes
    task automatic test_field_extremes();
        settle();
        apply_config(0, 0, 128, 32'h4000_0000, 38, 0);
        send_elem(8'd255, 8'sd127, $urandom, 1'b0);
        send_elem(8'd255, -8'sd128, $urandom, 1'b1);
        send_elem(8'd255, 8'sd127, $urandom, 1'b1);
        send_elem(8'd255, -8'sd128, $urandom, 1'b1);
        send_elem(8'd0, -8'sd128, $urandom, 1'b1);
        settle();
        apply_config(255, 32'h80, 128, 32'h4000_0000, 38, 0);
        send_elem(8'd0, 8'sd127, $urandom, 1'b1);
        send_elem(8'd255, -8'sd128, $urandom, 1'b1);
        send_elem(8'd0, -8'sd128, $urandom, 1'b1);
    endtask

    // exact halves round away from zero, shift of zero takes no rounding
    task automatic test_rounding();
        settle();
        apply_config(0, 0, 128, 32'h4000_0000, 31, 0);
        send_elem(8'd1, 8'sd1, $urandom, 1'b1);
        send_elem(8'd1, -8'sd1, $urandom, 1'b1);
        send_elem(8'd3, 8'sd1, $urandom, 1'b1);
        send_elem(8'd3, -8'sd1, $urandom, 1'b1);
        settle();
        apply_config(0, 0, 128, 1, 0, 0);
        send_elem(8'd2, 8'sd3, $urandom, 1'b1);
    endtask

    // zero multiplier, full multiplier with no shift, largest shift
    task automatic test_scale_extremes();
        settle();
        apply_config(0, 0, 77, 0, 30, 0);
        send_elem(8'd200, 8'sd100, $urandom, 1'b1);
        settle();
        apply_config(0, 0, 128, 32'h7FFF_FFFF, 0, 0);
        send_elem(8'd1, 8'sd1, $urandom, 1'b1);
        send_elem(8'd1, -8'sd1, $urandom, 1'b1);
        settle();
        apply_config(0, 0, 128, 32'h7FFF_FFFF, 63, 0);
        send_elem(8'd255, -8'sd128, $urandom, 1'b1);
    endtask

    // bias only on the last element, at both ends of its range
    task automatic test_bias();
        settle();
        apply_config(0, 0, 0, 32'h4000_0000, 30, 1);
        send_elem(8'd0, 8'sd0, 32'sd200, 1'b1);
        send_elem(8'd0, 8'sd0, 32'h7FFF_FFFF, 1'b1);
        send_elem(8'd0, 8'sd0, 32'h8000_0000, 1'b1);
        send_elem(8'd1, 8'sd1, 32'h8000_0000, 1'b0);
        send_elem(8'd0, 8'sd0, 32'sd5, 1'b1);
    endtask

    // phases of random runs, each under its own settings and idling mix
    task automatic test_random_runs();
        int goal;
        int phase_end;
        goal = items_sent + RANDOM_ITEMS - LONG_RUN;
        while (items_sent < goal)
        begin
            settle();
            if ($urandom_range(0, 2) != 0)
                apply_config($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255),
                             $urandom_range(32'h7FFF_FFFF, 32'h4000_0000),
                             $urandom_range(36, 47), $urandom_range(0, 1));
            else
                apply_config(pick(0, 255), pick(0, 255), pick(0, 255),
                             pick(0, 32'h7FFF_FFFF), pick(0, 63), $urandom_range(0, 1));
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            phase_end = items_sent + $urandom_range(60, 200);
            while (items_sent < phase_end && items_sent < goal)
                random_run(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                       : $urandom_range(1, 16));
        end
    endtask

    // one long run of the largest products, far from the accumulator bounds
    task automatic test_long_run();
        settle();
        apply_config(0, 32'h80, 0, 32'h4000_0000, 47, 1);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
        for (int i = 0; i < LONG_RUN; i++)
            send_elem(8'd255, 8'sd127, $urandom_range(0, 20'hFFFFF) - 20'h80000,
                      i == LONG_RUN - 1);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        errors        = 0;
        items_sent    = 0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        // predictor starts from the register reset values
        cfg_act_zp  = 8'd0;
        cfg_wgt_zp  = 8'sd0;
        cfg_out_zp  = 8'd0;
        cfg_mult    = 31'h4000_0000;
        cfg_shift   = 6'd30;
        cfg_bias_en = 1'b0;
        dot_acc     = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_file();
        test_field_extremes();
        test_rounding();
        test_scale_extremes();
        test_bias();
        test_random_runs();
        test_long_run();

        settle();
        if (expected_bytes.size() != 0)
            report($sformatf("%0d results never arrived", expected_bytes.size()));
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
